[rtl/lpm_pkg.sv]
`default_nettype none

package lpm_pkg;

    localparam int unsigned ColorW   = 32;
    localparam int unsigned NumLayer = 4;
    localparam int unsigned SelW     = 5;
    localparam int unsigned MaskW    = NumLayer;
    localparam int unsigned LayerW   = 2;
    localparam int unsigned OrderW   = NumLayer * LayerW;
    localparam int unsigned StageNum = NumLayer;

    // Color shown where every layer is transparent
    localparam logic [ColorW-1:0] BgColor = 32'hFF00_0000;

    typedef logic [ColorW-1:0] t_color;
    typedef t_color            t_colors [NumLayer];

    // Draw order build state that rides along with each item
    typedef struct packed {
        logic [SelW-1:0]   sel;
        logic [MaskW-1:0]  mask;
        logic [OrderW-1:0] order;
    } t_ord_ctl;

    // Priority PROM, low nibble of each entry; address = {select[3:0], placed mask}
    localparam logic [3:0] PriProm [256] = '{
        4'h8,4'h9,4'h8,4'hA,4'h0,4'h5,4'h0,4'hF,4'h8,4'h9,4'h8,4'hA,4'h0,4'h5,4'h0,4'hF,
        4'h8,4'h9,4'h8,4'hB,4'h0,4'hD,4'h0,4'hF,4'h8,4'h9,4'h8,4'hA,4'h0,4'h5,4'h0,4'hF,
        4'h8,4'hA,4'h8,4'hA,4'h4,4'h5,4'h0,4'hF,4'h8,4'hA,4'h8,4'hA,4'h4,4'h5,4'h0,4'hF,
        4'h8,4'hA,4'h8,4'hA,4'h4,4'h7,4'hC,4'hF,4'h8,4'hA,4'h8,4'hA,4'h4,4'h5,4'h0,4'hF,
        4'h8,4'hB,4'h8,4'hB,4'hC,4'hF,4'hC,4'hF,4'h8,4'h9,4'h8,4'hA,4'h0,4'h5,4'h0,4'hF,
        4'h8,4'hB,4'h8,4'hB,4'hC,4'hF,4'hC,4'hF,4'h8,4'hA,4'h8,4'hA,4'h4,4'h5,4'h0,4'hF,
        4'hD,4'hD,4'hC,4'hE,4'hD,4'hD,4'hC,4'hF,4'h1,4'h5,4'h0,4'hA,4'h1,4'h5,4'h0,4'hF,
        4'hD,4'hD,4'hC,4'hF,4'hD,4'hD,4'hC,4'hF,4'h1,4'h9,4'h0,4'hA,4'h1,4'h5,4'h0,4'hF,
        4'hD,4'hD,4'hE,4'hE,4'hD,4'hD,4'hC,4'hF,4'h5,4'h5,4'h2,4'hA,4'h5,4'h5,4'h0,4'hF,
        4'hD,4'hD,4'hE,4'hE,4'hD,4'hD,4'hF,4'hF,4'h5,4'h5,4'hA,4'hA,4'h5,4'h5,4'h0,4'hF,
        4'hD,4'hD,4'hF,4'hF,4'hD,4'hD,4'hF,4'hF,4'h9,4'h9,4'h8,4'hA,4'h1,4'h5,4'h0,4'hF,
        4'hD,4'hD,4'hF,4'hF,4'hD,4'hD,4'hF,4'hF,4'h9,4'h9,4'hA,4'hA,4'h5,4'h5,4'h0,4'hF,
        4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,
        4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,
        4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,
        4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF
    };

endpackage

`default_nettype wire

[rtl/layer_priority_mixer_unit.sv]
`default_nettype none

// Channel     Dir  Handshake                           Payload
// s_axis      in   i_s_axis_tvalid / o_s_axis_tready   128-bit item: four layer colors
// m_axis      out  o_m_axis_tvalid / i_m_axis_tready   32-bit composited pixel color
// cfg         in   i_cfg_valid / o_cfg_ready           5-bit priority select
//
// One item per clock while m_axis does not stall; four PROM lookup
// stages build the draw order, then one paint stage drives the output register.
// The priority select is sampled as an item enters and travels with it.
// Reset clears all valid bits and sets the priority select to zero.
// A stall on m_axis freezes every stage at once; bubbles are not squeezed out.
module layer_priority_mixer_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // sprite_color, tile_one_color, tile_two_color, tile_three_color
    input  wire logic [4*lpm_pkg::ColorW-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // pixel_color
    output logic [lpm_pkg::ColorW-1:0]      o_m_axis_tdata,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [lpm_pkg::SelW-1:0]   i_cfg_data
);
    import lpm_pkg::*;

    logic            r_priority_select;
    logic [SelW-1:0] r_sel;
    logic            pipe_en;
    logic            stg_valid  [StageNum+1];
    t_ord_ctl        stg_ctl    [StageNum+1];
    t_colors         stg_colors [StageNum+1];

    // Priority select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else if (i_cfg_valid) begin
            r_sel <= i_cfg_data;
        end
    end

    // Track that the register has left reset once written or not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priority_select <= 1'b0;
        end else if (i_cfg_valid) begin
            r_priority_select <= 1'b1;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Whole pipeline moves when the output register is free or being taken
    assign pipe_en         = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;

    // Unpack the item and start an empty order
    assign stg_valid[0] = i_s_axis_tvalid;
    assign stg_ctl[0]   = '{sel: r_sel, mask: '0, order: '0};
    for (genvar k = 0; k < NumLayer; k++) begin : g_unpack
        assign stg_colors[0][k] = i_s_axis_tdata[k*ColorW +: ColorW];
    end

    // Four chained lookups, one per stage
    for (genvar g = 0; g < StageNum; g++) begin : g_order
        lpm_order_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (pipe_en),
            .i_valid  (stg_valid[g]),
            .i_ctl    (stg_ctl[g]),
            .i_colors (stg_colors[g]),
            .o_valid  (stg_valid[g+1]),
            .o_ctl    (stg_ctl[g+1]),
            .o_colors (stg_colors[g+1])
        );
    end

    lpm_paint u_paint (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (stg_valid[StageNum]),
        .i_order  (stg_ctl[StageNum].order),
        .i_colors (stg_colors[StageNum]),
        .o_valid  (o_m_axis_tvalid),
        .o_color  (o_m_axis_tdata)
    );

    // After the first lookup exactly one layer is placed
    a_first_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stg_valid[1] |-> $onehot(stg_ctl[1].mask))
        else $error("first lookup stage mask not one-hot");

    // After the second lookup at most two layers are placed
    a_mask_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stg_valid[2] |-> ($countones(stg_ctl[2].mask) <= 2))
        else $error("second lookup stage placed too many layers");

    // A frozen pipeline keeps its draw order
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pipe_en && stg_valid[StageNum]) |=> $stable(stg_ctl[StageNum]))
        else $error("draw order changed during stall");

    // Composited color is never zero: background and opaque layers are nonzero
    a_nonzero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata != '0))
        else $error("composited color is zero");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid directly after reset");

    // Select is back to zero right after reset
    a_reset_sel: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_sel == '0 && !r_priority_select))
        else $error("priority select not cleared by reset");

endmodule

`default_nettype wire

[rtl/lpm_order_stage.sv]
`default_nettype none

// One PROM lookup of the draw order build; the item's colors ride along.
module lpm_order_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire lpm_pkg::t_ord_ctl i_ctl,
    input  wire lpm_pkg::t_colors  i_colors,
    output logic                  o_valid,
    output lpm_pkg::t_ord_ctl     o_ctl,
    output lpm_pkg::t_colors      o_colors
);
    import lpm_pkg::*;

    logic [3:0]        prom_q;
    logic [LayerW-1:0] layer;
    t_ord_ctl          n_ctl;
    logic              r_valid;
    t_ord_ctl          r_ctl;
    t_colors           r_colors;

    // Look up the next layer and add it to the placed mask
    always_comb begin
        prom_q = PriProm[{i_ctl.sel[3:0], i_ctl.mask}];
        layer  = i_ctl.sel[SelW-1] ? prom_q[3:2] : prom_q[1:0];
        n_ctl       = i_ctl;
        n_ctl.mask  = i_ctl.mask | (MaskW'(1) << layer);
        n_ctl.order = {i_ctl.order[OrderW-LayerW-1:0], layer};
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl    <= n_ctl;
            r_colors <= i_colors;
        end
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_colors = r_colors;

endmodule

`default_nettype wire

[rtl/lpm_paint.sv]
`default_nettype none

// Paint the layers in draw order over the background; the last opaque one wins.
module lpm_paint (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [lpm_pkg::OrderW-1:0] i_order,
    input  wire lpm_pkg::t_colors           i_colors,
    output logic                            o_valid,
    output logic [lpm_pkg::ColorW-1:0]      o_color
);
    import lpm_pkg::*;

    t_color n_color;
    t_color slot_color [NumLayer];
    logic   r_valid;
    t_color r_color;

    // Slot 0 is painted first, slot 3 last
    always_comb begin
        n_color = BgColor;
        for (int k = 0; k < NumLayer; k++) begin
            slot_color[k] = i_colors[i_order[k*LayerW +: LayerW]];
            if (slot_color[k] != '0) begin
                n_color = slot_color[k];
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_color <= n_color;
        end
    end

    assign o_valid = r_valid;
    assign o_color = r_color;

endmodule

`default_nettype wire
